>>> rtl/sfad_pkg.sv
// ----------------------------------------------------------------------------
// sfad_pkg
// Shared constants for the short float add / divide unit.
// ----------------------------------------------------------------------------
package sfad_pkg;

  localparam int WordW = 24;
  localparam int ExpW  = 8;
  localparam int FracW = 15;
  localparam int SigW  = 24;
  localparam int CntW  = 5;

  localparam logic [CntW-1:0] SigSteps = 5'd24;
  localparam logic [10:0]     DivBias  = 11'd125;
  localparam logic [9:0]      ExpLimit = 10'd254;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] K_ADD  = 2'd0;
  localparam logic [1:0] K_ZERO = 2'd1;
  localparam logic [1:0] K_INF  = 2'd2;
  localparam logic [1:0] K_DIV  = 2'd3;

endpackage

>>> rtl/short_float_add_divide_unit.sv
// ----------------------------------------------------------------------------
// short_float_add_divide_unit
// 24-bit float add (truncating) and restoring divide, one bit per cycle.
// Add: exact cancellation goes straight to the result, else a serial align (up
// to 24 shifts), serial normalize if needed; divide overflow skips the steps.
// One word at a time; the next word is taken in the cycle after the result
// register loads. Reset (rst, synchronous) returns to idle, output empty.
// ----------------------------------------------------------------------------
module short_float_add_divide_unit
  import sfad_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [WordW-1:0] operand_a,
  input  logic [WordW-1:0] operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] result_value,
  output logic             overflow_flag
);

  logic [2:0]      state;
  logic [1:0]      kind;
  logic            mode_q, sub_q, dnz, sgn;
  logic [WordW-1:0] a_q, b_q;
  logic [8:0]      e_q;
  logic [CntW-1:0] cnt;
  logic [SigW-1:0] mb, ms, den;
  logic [SigW:0]   q, r;

  // setup
  logic            a_ge, c;
  logic [WordW-1:0] big, sm;
  logic [7:0]      d;
  logic [SigW-1:0] f_big, f_sm, f_a, f_b;
  logic [10:0]     ediv;
  logic            dovf;
  logic [SigW:0]   num;

  // align / add
  logic [SigW-1:0] m_sub, m_add;
  logic [SigW:0]   s_add;
  logic [8:0]      e_add;

  // divide step
  logic [SigW:0]   t;
  logic            t_ge;
  logic [30:0]     dsum;
  logic [WordW-1:0] res;

  always_comb begin
    a_ge  = a_q[22:0] >= b_q[22:0];
    big   = a_ge ? a_q : b_q;
    sm    = a_ge ? b_q : a_q;
    d     = big[22:15] - sm[22:15];
    f_big = {1'b1, big[FracW-1:0], 8'b0};
    f_sm  = {1'b1, sm[FracW-1:0], 8'b0};
    f_a   = {1'b1, a_q[FracW-1:0], 8'b0};
    f_b   = {1'b1, b_q[FracW-1:0], 8'b0};
    c     = a_q[FracW-1:0] >= b_q[FracW-1:0];
    ediv  = {3'b0, a_q[22:15]} + DivBias - {3'b0, b_q[22:15]} + {10'b0, c};
    dovf  = ediv[10] || (ediv[9:0] >= ExpLimit);
    num   = c ? {1'b0, f_a} : {f_a, 1'b0};
  end

  always_comb begin
    m_sub = mb - ms;
    s_add = {1'b0, mb} + {1'b0, ms};
    e_add = e_q;
    if (dnz) begin
      m_add = s_add[SigW-1:0];
    end else begin
      m_add = s_add[SigW:1];
      e_add = e_add + 9'd1;
    end
    if (m_add[23]) begin
      m_add = m_add >> 1;
      if (dnz) begin
        m_add[22] = 1'b0;
      end
      e_add = e_add + 9'd1;
    end
  end

  always_comb begin
    t    = {r[SigW-1:0], 1'b0};
    t_ge = t >= {1'b0, den};
    dsum = {e_q[7:0], 23'b0} + {7'b0, q[SigW:1]} + {30'b0, q[0]};
    case (kind)
      K_ADD:   res = {sgn, e_q[7:0], mb[22:8]};
      K_ZERO:  res = '0;
      K_INF:   res = {sgn, 8'hFF, 15'b0};
      K_DIV:   res = {sgn, dsum[30:8]};
      default: res = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_q    <= operand_a;
            b_q    <= operand_b;
            mode_q <= mode;
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (mode_q) begin
            sgn <= a_q[23] ^ b_q[23];
            e_q <= {1'b0, ediv[7:0]};
            if (dovf) begin
              kind  <= K_INF;
              state <= S_DONE;
            end else begin
              kind  <= K_DIV;
              den   <= f_b;
              r     <= num - {1'b0, f_b};
              q     <= {{SigW{1'b0}}, 1'b1};
              cnt   <= SigSteps;
              state <= S_DIV;
            end
          end else begin
            sgn   <= a_ge ? a_q[23] : b_q[23];
            sub_q <= a_q[23] ^ b_q[23];
            dnz   <= (d != 8'd0);
            e_q   <= {1'b0, big[22:15]};
            cnt   <= (d > 8'd24) ? SigSteps : d[CntW-1:0];
            kind  <= K_ADD;
            if ((a_q[23] ^ b_q[23]) && (a_q[22:0] == b_q[22:0])) begin
              kind  <= K_ZERO;
              state <= S_DONE;
            end else if (a_q[23] ^ b_q[23]) begin
              mb    <= f_big >> 1;
              ms    <= f_sm >> 1;
              state <= S_ALIGN;
            end else begin
              mb    <= {1'b0, big[FracW-1:0], 8'b0};
              ms    <= (d != 8'd0) ? f_sm : {1'b0, sm[FracW-1:0], 8'b0};
              state <= S_ALIGN;
            end
          end
        end
        S_ALIGN: begin
          if (cnt != '0) begin
            ms  <= ms >> 1;
            cnt <= cnt - 5'd1;
          end else if (sub_q) begin
            if (m_sub[22]) begin
              mb    <= {1'b0, m_sub[21:0], 1'b0};
              state <= S_DONE;
            end else begin
              mb    <= {m_sub[22:0], 1'b0};
              state <= S_NORM;
            end
          end else begin
            mb    <= m_add;
            e_q   <= {1'b0, e_add[7:0]};
            state <= S_DONE;
          end
        end
        S_NORM: begin
          if ((cnt < SigSteps) && !mb[23]) begin
            mb <= {mb[22:0], 1'b0};
            if (e_q == 9'd0) begin
              kind  <= K_ZERO;
              state <= S_DONE;
            end else begin
              e_q <= e_q - 9'd1;
              cnt <= cnt + 5'd1;
            end
          end else begin
            mb[23] <= 1'b0;
            state  <= S_DONE;
          end
        end
        S_DIV: begin
          if (t_ge) begin
            r <= t - {1'b0, den};
            q <= {q[SigW-1:0], 1'b1};
          end else begin
            r <= t;
            q <= {q[SigW-1:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            result_value  <= res;
            overflow_flag <= (kind == K_INF);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");
  a_ovf_is_inf: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_flag |-> result_value[22:0] == {8'hFF, 15'b0})
    else $error("overflow without infinity");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && state != S_SETUP |-> cnt <= SigSteps)
    else $error("step counter out of range");
`endif

endmodule
